// ===== design/cpb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cpb_pkg
// Shared types and constants for the colour palette builder and mapper.
// ----------------------------------------------------------------------------
package cpb_pkg;

    localparam int CAPACITY = 255;
    localparam int IDX_W    = $clog2(CAPACITY + 1);

    typedef logic [IDX_W-1:0] idx_t;

    typedef enum logic
    {
        OP_INSERT = 1'b0,
        OP_LOOKUP = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        ST_EXISTING  = 2'd0,
        ST_ADDED     = 2'd1,
        ST_FULL      = 2'd2,
        ST_UNMATCHED = 2'd3
    } status_t;

    // One search token as it moves along the row of cells
    typedef struct packed
    {
        logic        valid;
        op_t         op;
        logic [23:0] color;
        logic        resolved;
        status_t     status;
        idx_t        idx;
        idx_t        count;
    } item_t;

endpackage
`default_nettype wire

// ===== design/cpb_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cpb_in_if
// Pixel channel: operation and RGB colour with valid/ready handshake.
// ----------------------------------------------------------------------------
interface cpb_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output operation, output red, output green,
                    output blue, input ready);
    modport sink   (input valid, input operation, input red, input green,
                    input blue, output ready);
endinterface
`default_nettype wire

// ===== design/cpb_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cpb_out_if
// Result channel: palette index, status and entries in use.
// ----------------------------------------------------------------------------
interface cpb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] color_index;
    logic [1:0] status;
    logic [7:0] entries_used;

    modport source (output valid, output color_index, output status,
                    output entries_used, input ready);
    modport sink   (input valid, input color_index, input status,
                    input entries_used, output ready);
endinterface
`default_nettype wire

// ===== design/color_palette_builder_and_mapper.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// color_palette_builder_and_mapper
// Exact-match colour palette with insert and lookup, built as a row of cells.
// ----------------------------------------------------------------------------
// Each pixel beat travels down a row of CAPACITY cells, one cell per cycle;
// cell i holds palette entry i. An insert beat that misses claims the first
// empty cell it meets, so the following beat, one cell behind, already sees
// it. A new beat is taken every cycle while the row is not stalled; its
// result leaves the last cell after passing through every cell register.
// When the result beat is held, the whole row stalls. Entry count and
// occupancy are cleared at reset; entry contents are not.
// ----------------------------------------------------------------------------
module color_palette_builder_and_mapper
(
    input  wire logic clk,
    input  wire logic rst_n,
    cpb_in_if.sink    pixel,
    cpb_out_if.source result
);

    cpb_pkg::item_t chain [cpb_pkg::CAPACITY+1];
    cpb_pkg::item_t head;
    cpb_pkg::item_t last;
    logic           adv;

    assign last        = chain[cpb_pkg::CAPACITY];
    assign adv         = !last.valid || result.ready;
    assign pixel.ready = adv;

    always_comb
    begin
        head          = '0;
        head.valid    = pixel.valid;
        head.op       = cpb_pkg::op_t'(pixel.operation);
        head.color    = {pixel.red, pixel.green, pixel.blue};
        head.resolved = 1'b0;
    end

    assign chain[0] = head;

    for (genvar i = 0; i < cpb_pkg::CAPACITY; i++)
    begin : g_cell
        cpb_cell u_cell
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .adv        (adv),
            .cell_index (cpb_pkg::idx_t'(i)),
            .item_in    (chain[i]),
            .item_out   (chain[i+1])
        );
    end

    assign result.valid        = last.valid;
    assign result.entries_used = 8'(last.count);

    always_comb
    begin
        if (last.resolved)
        begin
            result.status      = last.status;
            result.color_index = 8'(last.idx);
        end
        else
        begin
            // went through every cell without a match or a free slot
            result.status      = (last.op == cpb_pkg::OP_LOOKUP) ?
                                 cpb_pkg::ST_UNMATCHED : cpb_pkg::ST_FULL;
            result.color_index = 8'd0;
        end
    end

endmodule
`default_nettype wire

// ===== design/cpb_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cpb_cell
// One palette entry: compares the passing token, claims itself on a miss
// insert, and registers the token for the next cell.
// ----------------------------------------------------------------------------
module cpb_cell
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          adv,
    input  wire cpb_pkg::idx_t cell_index,
    input  wire cpb_pkg::item_t item_in,
    output cpb_pkg::item_t      item_out
);

    logic           occ_reg;
    logic           occ_next;
    logic [23:0]    entry_reg;
    logic           valid_reg;
    cpb_pkg::item_t item_reg;
    cpb_pkg::item_t item_next;
    logic           hit;
    logic           claim;

    assign hit   = occ_reg && (entry_reg == item_in.color);
    assign claim = item_in.valid && !item_in.resolved && !occ_reg
                   && (item_in.op == cpb_pkg::OP_INSERT);
    assign occ_next = occ_reg || (adv && claim);

    always_comb
    begin
        item_next = item_in;
        if (!item_in.resolved)
        begin
            if (hit)
            begin
                item_next.resolved = 1'b1;
                item_next.status   = cpb_pkg::ST_EXISTING;
                item_next.idx      = cell_index;
            end
            else if (claim)
            begin
                item_next.resolved = 1'b1;
                item_next.status   = cpb_pkg::ST_ADDED;
                item_next.idx      = cell_index;
            end
        end
        // count of filled cells as this token sees them, its own write included
        if (occ_reg || claim)
        begin
            item_next.count = item_in.count + cpb_pkg::idx_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
            if (adv)
            begin
                valid_reg <= item_in.valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && claim)
        begin
            entry_reg <= item_in.color;
        end
        if (adv)
        begin
            item_reg <= item_next;
        end
    end

    always_comb
    begin
        item_out       = item_reg;
        item_out.valid = valid_reg;
    end

endmodule
`default_nettype wire

// ===== design/cpb_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cpb_checker
// Port-level checks on the result channel of the palette block.
// ----------------------------------------------------------------------------
module cpb_checker
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] color_index,
    input wire logic [1:0] status,
    input wire logic [7:0] entries_used
);

    localparam logic [7:0] CAP8 = 8'(cpb_pkg::CAPACITY);

    a_added_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == cpb_pkg::ST_ADDED)
        |-> entries_used == color_index + 8'd1)
        else $error("added entry not last in use");

    a_zero_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == cpb_pkg::ST_FULL || status == cpb_pkg::ST_UNMATCHED)
        |-> color_index == 8'd0)
        else $error("non-zero index without a match");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == cpb_pkg::ST_FULL) |-> entries_used == CAP8)
        else $error("full reported below capacity");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready
        |=> out_valid && $stable(color_index) && $stable(status)
            && $stable(entries_used))
        else $error("stalled result beat changed");

endmodule

bind color_palette_builder_and_mapper cpb_checker u_cpb_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .color_index  (result.color_index),
    .status       (result.status),
    .entries_used (result.entries_used)
);
`default_nettype wire
